// ----- rtl/mttc_pkg.sv -----
package mttc_pkg;

  // Widths of the serial arithmetic units.
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned SQ_RAD_W   = 68;
  localparam int unsigned SQ_ROOT_W  = SQ_RAD_W / 2;
  localparam int unsigned SQ_REM_W   = SQ_ROOT_W + 3;
  localparam int unsigned DIV_NUM_W  = 34;
  localparam int unsigned DIV_DEN_W  = 32;
  localparam int unsigned THR_W      = 16;
  localparam logic [THR_W-1:0] THR_RESET = 16'd1;

endpackage

// ----- rtl/mttc_mul.sv -----
module mttc_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mttc_pkg::MUL_W-1:0]   a_i,
  input  logic [mttc_pkg::MUL_W-1:0]   b_i,
  output logic                         done_o,
  output logic [2*mttc_pkg::MUL_W-1:0] prod_o
);
  import mttc_pkg::*;

  localparam int unsigned CW = $clog2(MUL_W);
  localparam logic [CW-1:0] LAST = CW'(MUL_W - 1);

  logic [MUL_W-1:0]   a_q;
  logic [2*MUL_W-1:0] p_q;
  logic [CW-1:0]      cnt_q;
  logic               busy_q, done_q;
  logic [MUL_W:0]     sum;

  // Upper half takes the multiplicand when the low bit of the shifting multiplier is set.
  assign sum = {1'b0, p_q[2*MUL_W-1:MUL_W]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MUL_W{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= {sum, p_q[MUL_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

// ----- rtl/mttc_sqrt.sv -----
module mttc_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mttc_pkg::SQ_RAD_W-1:0]  rad_i,
  output logic                           done_o,
  output logic [mttc_pkg::SQ_ROOT_W-1:0] root_o
);
  import mttc_pkg::*;

  localparam int unsigned CW = $clog2(SQ_ROOT_W);
  localparam logic [CW-1:0] LAST = CW'(SQ_ROOT_W - 1);

  logic [SQ_RAD_W-1:0]  rad_q;
  logic [SQ_ROOT_W-1:0] root_q;
  logic [SQ_REM_W-1:0]  rem_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q;
  logic [SQ_REM_W-1:0]  rem_sh, trial;
  logic                 take;

  // One root bit per cycle from the next pair of radicand bits.
  assign rem_sh = {rem_q[SQ_REM_W-3:0], rad_q[SQ_RAD_W-1:SQ_RAD_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQ_RAD_W-3:0], 2'b00};
      root_q <= {root_q[SQ_ROOT_W-2:0], take};
      rem_q  <= take ? rem_sh - trial : rem_sh;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- rtl/mttc_div.sv -----
module mttc_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mttc_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [mttc_pkg::DIV_DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [31:0]                    quot_o
);
  import mttc_pkg::*;

  localparam int unsigned NW = DIV_NUM_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW);
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  logic [NW-1:0]        dvd_q;
  logic [DIV_DEN_W-1:0] den_q, rem_q;
  logic [31:0]          quot_q;
  logic                 ovf_q;
  logic [CW-1:0]        cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 take;

  assign rem_sh = {rem_q, dvd_q[NW-1]};
  assign take   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A quotient bit pushed out of the top marks a result that saturates.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= {num_i, {FRAC_BITS{1'b0}}};
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[NW-2:0], 1'b0};
      rem_q  <= take ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
      quot_q <= {quot_q[30:0], take};
      ovf_q  <= ovf_q | quot_q[31];
    end
  end

  assign done_o = done_q;
  assign quot_o = ovf_q ? '1 : quot_q;

endmodule

// ----- rtl/min_time_to_collision.sv -----
// An item without an object goes straight from S_IDLE to S_FIN. An object runs the
// bit-serial multiplier, square root and divider as it needs them, one after another.
// The item that ends a frame also passes S_EMIT, which loads the output register.
// Throughput: one item at a time; the next is taken once the current one is finished.
// Reset clears the running minimum, the output register and sets the threshold to 1.
module min_time_to_collision #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mttc_pkg::THR_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // obj_pos_x, obj_pos_y, obj_speed, obj_accel, ego_speed, ego_accel
  input  logic [191:0]                  s_axis_tdata,
  // object_valid
  input  logic                          s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // min_ttc, distance_at_min
  output logic [63:0]                   m_axis_tdata,
  // collision_found
  output logic                          m_axis_tuser
);
  import mttc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MX, S_MY, S_SQD, S_DEC, S_MV, S_MP, S_CALC, S_SQS, S_DIV, S_FIN, S_EMIT
  } state_e;

  state_e state_q;

  logic [THR_W-1:0]     thr_q;
  logic                 last_q;
  logic [31:0]          my_q, mv_q, av_q, d_q;
  logic signed [32:0]   v_q, a_q;
  logic [63:0]          sumsq_q, v2_q, p_q;
  logic [31:0]          ttc_q;
  logic                 found_q;
  logic [31:0]          best_ttc_q, best_dist_q;
  logic                 any_q;
  logic                 ovalid_q, ouser_q;
  logic [63:0]          odata_q;

  logic                 mul_go_q, sq_go_q, div_go_q;
  logic [MUL_W-1:0]     mul_a_q, mul_b_q;
  logic [SQ_RAD_W-1:0]  sq_rad_q;
  logic [DIV_NUM_W-1:0] div_num_q;
  logic [DIV_DEN_W-1:0] div_den_q;

  logic                 mul_done, sq_done, div_done;
  logic [2*MUL_W-1:0]   prod;
  logic [SQ_ROOT_W-1:0] root;
  logic [31:0]          quot;

  logic signed [32:0]   v_in, a_in;
  logic [32:0]          v_abs, a_abs;
  logic [31:0]          x_in, y_in;
  logic [DIV_NUM_W-1:0] num_pos;

  assign x_in  = s_axis_tdata[31:0];
  assign y_in  = s_axis_tdata[63:32];
  assign v_in  = $signed({s_axis_tdata[159], s_axis_tdata[159:128]})
               - $signed({s_axis_tdata[95], s_axis_tdata[95:64]});
  assign a_in  = $signed({s_axis_tdata[191], s_axis_tdata[191:160]})
               - $signed({s_axis_tdata[127], s_axis_tdata[127:96]});
  assign v_abs = v_in[32] ? 33'(-v_in) : v_in;
  assign a_abs = a_in[32] ? 33'(-a_in) : a_in;

  // Numerator of the root for a positive relative acceleration.
  assign num_pos = v_q[32] ? DIV_NUM_W'(root) + {2'b00, mv_q}
                           : DIV_NUM_W'(root) - {2'b00, v_q[31:0]};

  mttc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_go_q),
    .a_i    (mul_a_q),
    .b_i    (mul_b_q),
    .done_o (mul_done),
    .prod_o (prod)
  );

  mttc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_go_q),
    .rad_i  (sq_rad_q),
    .done_o (sq_done),
    .root_o (root)
  );

  mttc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go_q),
    .num_i  (div_num_q),
    .den_i  (div_den_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= THR_RESET;
      best_ttc_q  <= '1;
      best_dist_q <= '0;
      any_q       <= 1'b0;
      ovalid_q    <= 1'b0;
      ouser_q     <= 1'b0;
      odata_q     <= '0;
      mul_go_q    <= 1'b0;
      sq_go_q     <= 1'b0;
      div_go_q    <= 1'b0;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      mul_go_q <= 1'b0;
      sq_go_q  <= 1'b0;
      div_go_q <= 1'b0;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (ovalid_q && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            last_q  <= s_axis_tlast;
            found_q <= 1'b0;
            my_q    <= y_in[31] ? 32'(-y_in) : y_in;
            v_q     <= v_in;
            a_q     <= a_in;
            mv_q    <= v_abs[31:0];
            av_q    <= a_abs[31:0];
            if (s_axis_tuser) begin
              mul_a_q  <= x_in[31] ? 32'(-x_in) : x_in;
              mul_b_q  <= x_in[31] ? 32'(-x_in) : x_in;
              mul_go_q <= 1'b1;
              state_q  <= S_MX;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_MX: begin
          if (mul_done) begin
            sumsq_q  <= prod;
            mul_a_q  <= my_q;
            mul_b_q  <= my_q;
            mul_go_q <= 1'b1;
            state_q  <= S_MY;
          end
        end
        S_MY: begin
          if (mul_done) begin
            sq_rad_q <= SQ_RAD_W'(sumsq_q + prod);
            sq_go_q  <= 1'b1;
            state_q  <= S_SQD;
          end
        end
        S_SQD: begin
          if (sq_done) begin
            d_q     <= root[31:0];
            state_q <= S_DEC;
          end
        end
        S_DEC: begin
          if (d_q == '0) begin
            ttc_q   <= '0;
            found_q <= 1'b1;
            state_q <= S_FIN;
          end else if (av_q < {16'd0, thr_q}) begin
            // Constant speed: distance over closing speed.
            if (v_q <= 0) begin
              state_q <= S_FIN;
            end else begin
              div_num_q <= {2'b00, d_q};
              div_den_q <= v_q[31:0];
              div_go_q  <= 1'b1;
              state_q   <= S_DIV;
            end
          end else if (a_q == 0) begin
            state_q <= S_FIN;
          end else begin
            mul_a_q  <= mv_q;
            mul_b_q  <= mv_q;
            mul_go_q <= 1'b1;
            state_q  <= S_MV;
          end
        end
        S_MV: begin
          if (mul_done) begin
            v2_q     <= prod;
            mul_a_q  <= av_q;
            mul_b_q  <= d_q;
            mul_go_q <= 1'b1;
            state_q  <= S_MP;
          end
        end
        S_MP: begin
          if (mul_done) begin
            p_q     <= prod;
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          if (a_q > 0) begin
            sq_rad_q <= SQ_RAD_W'(v2_q) + SQ_RAD_W'({p_q, 1'b0});
            sq_go_q  <= 1'b1;
            state_q  <= S_SQS;
          end else if (v_q <= 0 || {p_q, 1'b0} > {1'b0, v2_q}) begin
            // Opening gap or no real root while braking relative to the object.
            state_q <= S_FIN;
          end else begin
            sq_rad_q <= SQ_RAD_W'(v2_q - {p_q[62:0], 1'b0});
            sq_go_q  <= 1'b1;
            state_q  <= S_SQS;
          end
        end
        S_SQS: begin
          if (sq_done) begin
            div_num_q <= a_q[32] ? {2'b00, v_q[31:0]} - DIV_NUM_W'(root) : num_pos;
            div_den_q <= av_q;
            div_go_q  <= 1'b1;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            ttc_q   <= quot;
            found_q <= 1'b1;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (found_q && (!any_q || ttc_q < best_ttc_q)) begin
            best_ttc_q  <= ttc_q;
            best_dist_q <= d_q;
            any_q       <= 1'b1;
          end
          state_q <= last_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!ovalid_q || m_axis_tready) begin
            ovalid_q    <= 1'b1;
            ouser_q     <= any_q;
            odata_q     <= {best_dist_q, best_ttc_q};
            best_ttc_q  <= '1;
            best_dist_q <= '0;
            any_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule

// ----- tb/sv/min_time_to_collision_tb.sv -----
module min_time_to_collision_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = 16;
  localparam int unsigned N_RANDOM = 1750;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam int HOLD_CYCLES = 2000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        valid_obj;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] obj_spd;
    logic [31:0] obj_acc;
    logic [31:0] ego_spd;
    logic [31:0] ego_acc;
    logic        last_obj;
  } obj_beat_t;

  typedef struct packed {
    logic        found;
    logic [31:0] ttc;
    logic [31:0] distance;
  } frame_res_t;

  // A directed row; has_fixed marks rows whose frame result is typed in.
  typedef struct packed {
    obj_beat_t  beat;
    logic       has_fixed;
    frame_res_t fixed;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mttc_pkg::THR_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [191:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic m_axis_tuser;

  always #1 clk_i = ~clk_i;

  min_time_to_collision #(.FRAC_BITS(FRAC)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  // Predictor state.
  logic [31:0] run_best_ttc = ALL_ONES;
  logic [31:0] run_best_dist = '0;
  logic        run_found = 1'b0;
  logic [15:0] zero_accel_thr = mttc_pkg::THR_RESET;

  frame_res_t frame_results_q[$];
  int mismatch_count = 0;
  int frames_seen = 0;
  longint unsigned cycle_count = 0;
  bit hold_off = 1'b0;

  function automatic logic [67:0] floor_sqrt(input logic [67:0] rad);
    logic [67:0] rem;
    logic [67:0] root;
    logic [67:0] trial;
    rem = '0;
    root = '0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | ((rad >> (2 * i)) & 68'd3);
      root = root << 1;
      trial = (root << 1) | 68'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 68'd1;
      end
    end
    return root;
  endfunction

  function automatic logic [31:0] sat_quotient(input logic [67:0] num,
                                               input logic [67:0] den);
    logic [99:0] q;
    q = ({32'd0, num} << FRAC) / {32'd0, den};
    return (q > 100'hFFFF_FFFF) ? ALL_ONES : q[31:0];
  endfunction

  // Returns 1 when the object has a time to collision, placed in ttc.
  function automatic bit object_ttc(input logic [63:0] d, input longint v,
                                    input longint a, output logic [31:0] ttc);
    logic [63:0] av;
    logic [63:0] mv;
    logic [67:0] v2;
    logic [67:0] p2;
    logic [67:0] s;
    ttc = '0;
    if (d == 0) return 1'b1;
    av = (a < 0) ? -a : a;
    if (av < zero_accel_thr) begin
      if (v <= 0) return 1'b0;
      ttc = sat_quotient(68'(d), 68'(v));
      return 1'b1;
    end
    if (a == 0) return 1'b0;
    mv = (v < 0) ? -v : v;
    v2 = 68'(mv) * 68'(mv);
    p2 = (68'(av) * 68'(d)) << 1;
    if (a > 0) begin
      s = floor_sqrt(v2 + p2);
      ttc = sat_quotient((v >= 0) ? s - 68'(mv) : s + 68'(mv), 68'(av));
      return 1'b1;
    end
    if (v <= 0 || p2 > v2) return 1'b0;
    s = floor_sqrt(v2 - p2);
    ttc = sat_quotient(68'(mv) - s, 68'(av));
    return 1'b1;
  endfunction

  // Folds one object into the running minimum; returns 1 with a frame result.
  function automatic bit fold_object(input obj_beat_t b, output frame_res_t res);
    longint mx;
    longint my;
    logic [63:0] d;
    logic [31:0] t;
    res = '0;
    if (b.valid_obj) begin
      mx = $signed(b.pos_x);
      my = $signed(b.pos_y);
      if (mx < 0) mx = -mx;
      if (my < 0) my = -my;
      d = 64'(floor_sqrt(68'(mx) * 68'(mx) + 68'(my) * 68'(my)));
      if (object_ttc(d, longint'($signed(b.ego_spd)) - longint'($signed(b.obj_spd)),
                     longint'($signed(b.ego_acc)) - longint'($signed(b.obj_acc)), t)
          && (!run_found || t < run_best_ttc)) begin
        run_best_ttc = t;
        run_best_dist = d[31:0];
        run_found = 1'b1;
      end
    end
    if (b.last_obj) begin
      res = '{found: run_found, ttc: run_best_ttc, distance: run_best_dist};
      run_best_ttc = ALL_ONES;
      run_best_dist = '0;
      run_found = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_beat(input obj_beat_t b, input bit has_fixed,
                           input frame_res_t fixed);
    frame_res_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b.ego_acc, b.ego_spd, b.obj_acc, b.obj_spd, b.pos_y, b.pos_x};
    s_axis_tuser  <= b.valid_obj;
    s_axis_tlast  <= b.last_obj;
    do @(posedge clk_i); while (!s_axis_tready);
    if (fold_object(b, res)) begin
      if (has_fixed && res !== fixed) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("directed row disagrees with predictor: %h vs %h", fixed, res);
      end
      frame_results_q.insert(frame_results_q.size(), res);
    end
  endtask

  // Random gap before the next beat; lowers valid only when a gap is taken.
  task automatic sender_gap();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    zero_accel_thr = value;
  endtask

  function automatic logic [31:0] rand_q(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 200 << FRAC)) - (100 << FRAC));
      2: return 32'($signed($urandom_range(0, 40 << FRAC)) - (20 << FRAC));
      3: return '0;
      default: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic obj_beat_t random_beat(input bit last);
    obj_beat_t b;
    int k;
    k = $urandom_range(0, 9);
    b.valid_obj = ($urandom_range(0, 15) != 0);
    b.last_obj = last;
    b.pos_x   = rand_q((k == 0) ? 0 : (k == 1) ? 4 : (k == 2) ? 3 : 1);
    b.pos_y   = rand_q((k == 0) ? 0 : (k < 5) ? 3 : 2);
    b.obj_spd = rand_q((k == 0) ? 0 : (k == 3) ? 4 : 2);
    b.ego_spd = rand_q((k == 0) ? 0 : 2);
    b.obj_acc = rand_q((k == 0) ? 0 : (k == 5) ? 3 : (k == 6) ? 4 : 2);
    b.ego_acc = (k == 7) ? b.obj_acc + $urandom_range(0, 3) - 1 : rand_q((k == 0) ? 0 : 2);
    return b;
  endfunction

  // Object helper for the directed table.
  function automatic obj_beat_t mk(input logic [31:0] x, input logic [31:0] y,
                                   input logic [31:0] os, input logic [31:0] oa,
                                   input logic [31:0] es, input logic [31:0] ea,
                                   input logic vld, input logic last);
    return '{valid_obj: vld, pos_x: x, pos_y: y, obj_spd: os, obj_acc: oa,
             ego_spd: es, ego_acc: ea, last_obj: last};
  endfunction

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam frame_res_t EMPTY_RES = '{found: 1'b0, ttc: 32'hFFFF_FFFF, distance: 32'd0};
  localparam frame_res_t ZERO_RES  = '{found: 1'b1, ttc: 32'd0, distance: 32'd0};

  stim_row_t directed_rows[] = '{
    // Empty frame right after reset.
    '{mk(0, 0, 0, 0, 0, 0, 1'b0, 1'b1), 1'b1, EMPTY_RES},
    // Zero distance.
    '{mk(0, 0, 0, 0, ONE, 0, 1'b1, 1'b1), 1'b1, ZERO_RES},
    // Constant speed, 10 m at 2 m/s.
    '{mk(10 * ONE, 0, 0, 0, 2 * ONE, 0, 1'b1, 1'b1), 1'b0, '0},
    // Gap not closing.
    '{mk(10 * ONE, 0, 2 * ONE, 0, 0, 0, 1'b1, 1'b1), 1'b1, EMPTY_RES},
    // Positive relative acceleration, negative speed.
    '{mk(3 * ONE, 4 * ONE, ONE, 0, 0, ONE, 1'b1, 1'b1), 1'b0, '0},
    // Negative acceleration, negative discriminant.
    '{mk(100 * ONE, 0, 0, 2 * ONE, ONE, 0, 1'b1, 1'b1), 1'b1, EMPTY_RES},
    // Negative acceleration, real root.
    '{mk(ONE, 0, 0, ONE, 10 * ONE, 0, 1'b1, 1'b1), 1'b0, '0},
    // Large TTC saturates: tiny closing speed.
    '{mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 32'd1, 0, 1'b1, 1'b1), 1'b0, '0},
    // Quotient truncating to zero: huge speed, tiny distance.
    '{mk(32'd1, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 1'b1, 1'b1), 1'b0, '0},
    // Extremes of every field.
    '{mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1), 1'b0, '0},
    '{mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1), 1'b0, '0},
    '{mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF,
         1'b1, 1'b1), 1'b0, '0},
    // Tie: two equal objects, the first distance stays.
    '{mk(10 * ONE, 0, 0, 0, 2 * ONE, 0, 1'b1, 1'b0), 1'b0, '0},
    '{mk(0, 10 * ONE, 0, 0, 2 * ONE, 0, 1'b1, 1'b0), 1'b0, '0},
    // Invalid item with junk fields, then a closer object, then end marker.
    '{mk(0, 0, 0, 0, ONE, 0, 1'b0, 1'b0), 1'b0, '0},
    '{mk(ONE, 0, 0, 0, 4 * ONE, 0, 1'b1, 1'b0), 1'b0, '0},
    '{mk(0, 0, 0, 0, 0, 0, 1'b0, 1'b1), 1'b0, '0}
  };

  // Receiver: stalls on its own pattern, plus one long hold-off counted here.
  initial begin
    int phase;
    int hold_count;
    phase = 0;
    hold_count = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) begin
          hold_off = 1'b0;
          hold_count = 0;
        end
      end
      else if ((phase / 64) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    frame_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      frames_seen++;
      if (frame_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        want = frame_results_q.pop_front();
        if (m_axis_tuser !== want.found || m_axis_tdata[31:0] !== want.ttc
            || m_axis_tdata[63:32] !== want.distance) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("frame %0d: exp found=%b ttc=%h dist=%h, got found=%b ttc=%h dist=%h",
                     frames_seen, want.found, want.ttc, want.distance,
                     m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [15:0] thr_set[] = '{16'd0, 16'hFFFF, 16'd655, 16'd1};
    int n;
    int frame_len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].has_fixed,
                directed_rows[i].fixed);
    wait_drained();

    // Zero relative acceleration with zero threshold: no TTC.
    write_threshold(16'd0);
    send_beat(mk(10 * ONE, 0, 0, ONE, 2 * ONE, ONE, 1'b1, 1'b1), 1'b1, EMPTY_RES);
    wait_drained();

    // Long receiver hold-off while frames keep coming.
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_beat(random_beat(1'b1), 1'b0, '0);
    wait_drained();

    n = 0;
    foreach (thr_set[p]) begin
      write_threshold(thr_set[p]);
      while (n < (p + 1) * N_RANDOM / thr_set.size()) begin
        frame_len = $urandom_range(1, 6);
        for (int k = 0; k < frame_len; k++) begin
          sender_gap();
          send_beat(random_beat(k == frame_len - 1), 1'b0, '0);
          n++;
        end
      end
      wait_drained();
    end

    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- min_time_to_collision.f -----
rtl/mttc_pkg.sv
rtl/mttc_mul.sv
rtl/mttc_sqrt.sv
rtl/mttc_div.sv
rtl/min_time_to_collision.sv
tb/sv/min_time_to_collision_tb.sv
